/* sv/senm_pkg.sv */
// Shared types and constants for the sonar echo nearest-match block.
`timescale 1ns / 1ps

package senm_pkg;

    // Sectors and configuration registers
    localparam int NUM_SECTORS = 3;
    localparam int NUM_CFG_REGS = 2 * NUM_SECTORS;
    localparam int CFG_IDX_W = 3;
    localparam int SEC_W = 2;

    // Field widths
    localparam int DIST_W = 16;
    localparam int HEAD_W = 16;
    localparam int RES_W = 17;
    localparam int IN_DATA_W = 48;
    localparam int IN_USER_W = 4;
    localparam int OUT_DATA_W = 40;

    // Command codes
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;
    localparam logic [1:0] CMD_NONE = 2'd3;

    // Sector codes; the last code marks the end of a scan
    localparam logic [SEC_W-1:0] SEC_LEFT = 2'd0;
    localparam logic [SEC_W-1:0] SEC_MIDDLE = 2'd1;
    localparam logic [SEC_W-1:0] SEC_RIGHT = 2'd2;
    localparam logic [SEC_W-1:0] SEC_DONE = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_START = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_STOP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIDDLE_START = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIDDLE_STOP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_START = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_STOP = 3'd5;

    // Result when no sector matched
    localparam logic [RES_W-1:0] NO_MATCH = 17'h1FFFF;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic scan;
        logic emit;
    } senm_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } senm_status_t;

endpackage

/* sv/senm_ctrl.sv */
// Controller state machine for the sonar echo nearest-match block.
`timescale 1ns / 1ps

module senm_ctrl
    import senm_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [1:0]   item_cmd,
    input  senm_status_t status,
    output senm_cmd_t    ctrl_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;
    localparam logic [1:0] ST_SPARE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    // Take a word only between queries
    assign s_tready = (state_reg == ST_IDLE);
    assign accept = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        ctrl_cmd.accept = accept;
        ctrl_cmd.scan = 1'b0;
        ctrl_cmd.emit = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && item_cmd == CMD_QUERY) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                ctrl_cmd.scan = 1'b1;
                if (status.scan_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // Hold the result until the output register is free
                if (status.out_free) begin
                    ctrl_cmd.emit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SPARE: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* sv/senm_datapath.sv */
// Datapath: bounds, echo counts, echo memory, scan pointers, best match and output register.
`timescale 1ns / 1ps

module senm_datapath
    import senm_pkg::*;
#(
    parameter int ECHOES_PER_SECTOR = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [15:0]           cfg_data,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [IN_USER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  senm_cmd_t             ctrl_cmd,
    output senm_status_t          status
);

    localparam int DEPTH = NUM_SECTORS * ECHOES_PER_SECTOR;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(ECHOES_PER_SECTOR + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ECHOES_PER_SECTOR);
    localparam logic [ADDR_W-1:0] SEC_STRIDE = ADDR_W'(ECHOES_PER_SECTOR);

    // Input fields
    logic [1:0]              in_cmd;
    logic [SEC_W-1:0]        in_sector;
    logic [DIST_W-1:0]       in_echo;
    logic signed [HEAD_W-1:0] in_heading;
    logic [DIST_W-1:0]       in_dist;

    assign in_cmd = s_tuser[1:0];
    assign in_sector = s_tuser[3:2];
    assign in_echo = s_tdata[15:0];
    assign in_heading = $signed(s_tdata[31:16]);
    assign in_dist = s_tdata[47:32];

    // Configuration and control registers
    logic signed [HEAD_W-1:0] bound_reg [NUM_CFG_REGS];
    logic [CNT_W-1:0]         count_reg [NUM_SECTORS];
    logic [CNT_W-1:0]         count_next [NUM_SECTORS];
    logic [NUM_SECTORS-1:0]   match_reg, match_next;
    logic [SEC_W-1:0]         sec_reg, sec_next;
    logic [CNT_W-1:0]         idx_reg, idx_next;
    logic                     rd_valid_reg, rd_valid_next;
    logic                     best_valid_reg, best_valid_next;
    logic                     m_tvalid_reg, m_tvalid_next;

    // Payload registers
    logic [DIST_W-1:0] dist_reg;
    logic [DIST_W-1:0] best_val_reg;
    logic [DIST_W-1:0] best_diff_reg;
    logic [DIST_W-1:0] rd_data_reg;
    logic [RES_W-1:0]  res_dist_reg;
    logic [RES_W-1:0]  res_diff_reg;

    // Echo memory
    logic [DIST_W-1:0] echo_mem [DEPTH];
    logic              mem_we;
    logic [ADDR_W-1:0] wr_addr;
    logic              mem_re;
    logic [ADDR_W-1:0] rd_addr;

    logic [CNT_W-1:0]  add_count;
    logic              add_ok;
    logic [CNT_W-1:0]  cur_count;
    logic              cur_match;
    logic [DIST_W-1:0] cand_diff;
    logic              take_cand;

    assign cfg_ready = 1'b1;

    // Store bounds; writes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CFG_REGS; i++) begin
                bound_reg[i] <= '0;
            end
        end else if (cfg_valid && cfg_index < CFG_IDX_W'(NUM_CFG_REGS)) begin
            bound_reg[cfg_index] <= $signed(cfg_data);
        end
    end

    // Select the count of the sector being added to
    always_comb begin
        unique case (in_sector)
            SEC_LEFT:   add_count = count_reg[0];
            SEC_MIDDLE: add_count = count_reg[1];
            SEC_RIGHT:  add_count = count_reg[2];
            default:    add_count = CNT_FULL;
        endcase
        add_ok = (add_count < CNT_FULL);
    end

    // Select the count and match flag of the sector under scan
    always_comb begin
        unique case (sec_reg)
            SEC_LEFT: begin
                cur_count = count_reg[0];
                cur_match = match_reg[0];
            end
            SEC_MIDDLE: begin
                cur_count = count_reg[1];
                cur_match = match_reg[1];
            end
            SEC_RIGHT: begin
                cur_count = count_reg[2];
                cur_match = match_reg[2];
            end
            default: begin
                cur_count = '0;
                cur_match = 1'b0;
            end
        endcase
    end

    // Distance of the echo just read, and whether it beats the best so far
    always_comb begin
        cand_diff = (dist_reg >= rd_data_reg) ? (dist_reg - rd_data_reg)
                                              : (rd_data_reg - dist_reg);
        take_cand = rd_valid_reg && (!best_valid_reg || cand_diff < best_diff_reg);
    end

    // Next-state logic for counts, scan pointers and output handshake
    always_comb begin
        for (int i = 0; i < NUM_SECTORS; i++) begin
            count_next[i] = count_reg[i];
        end
        match_next = match_reg;
        sec_next = sec_reg;
        idx_next = idx_reg;
        rd_valid_next = 1'b0;
        best_valid_next = best_valid_reg || take_cand;
        mem_we = 1'b0;
        wr_addr = ADDR_W'(in_sector) * SEC_STRIDE + ADDR_W'(add_count);
        mem_re = 1'b0;
        rd_addr = ADDR_W'(sec_reg) * SEC_STRIDE + ADDR_W'(idx_reg);

        if (ctrl_cmd.accept) begin
            unique case (in_cmd)
                CMD_CLEAR: begin
                    for (int i = 0; i < NUM_SECTORS; i++) begin
                        count_next[i] = '0;
                    end
                end
                CMD_ADD: begin
                    if (add_ok) begin
                        mem_we = 1'b1;
                        count_next[in_sector] = add_count + CNT_W'(1);
                    end
                end
                CMD_QUERY: begin
                    for (int i = 0; i < NUM_SECTORS; i++) begin
                        match_next[i] = (bound_reg[2*i] < in_heading)
                                     && (in_heading < bound_reg[2*i+1])
                                     && (count_reg[i] != '0);
                    end
                    sec_next = SEC_LEFT;
                    idx_next = '0;
                    best_valid_next = 1'b0;
                end
                CMD_NONE: begin
                end
                default: begin
                end
            endcase
        end else if (ctrl_cmd.scan && sec_reg != SEC_DONE) begin
            // Read one echo a cycle; skip sectors that do not match
            if (cur_match && idx_reg < cur_count) begin
                mem_re = 1'b1;
                rd_valid_next = 1'b1;
                if (idx_reg + CNT_W'(1) == cur_count) begin
                    sec_next = sec_reg + SEC_W'(1);
                    idx_next = '0;
                end else begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end else begin
                sec_next = sec_reg + SEC_W'(1);
                idx_next = '0;
            end
        end

        if (ctrl_cmd.emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SECTORS; i++) begin
                count_reg[i] <= '0;
            end
            match_reg <= '0;
            sec_reg <= SEC_DONE;
            idx_reg <= '0;
            rd_valid_reg <= 1'b0;
            best_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            for (int i = 0; i < NUM_SECTORS; i++) begin
                count_reg[i] <= count_next[i];
            end
            match_reg <= match_next;
            sec_reg <= sec_next;
            idx_reg <= idx_next;
            rd_valid_reg <= rd_valid_next;
            best_valid_reg <= best_valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Echo memory with registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            echo_mem[wr_addr] <= in_echo;
        end
        if (mem_re) begin
            rd_data_reg <= echo_mem[rd_addr];
        end
    end

    // Payload: query distance, best echo and result word
    always_ff @(posedge aclk) begin
        if (ctrl_cmd.accept && in_cmd == CMD_QUERY) begin
            dist_reg <= in_dist;
        end
        if (take_cand) begin
            best_val_reg <= rd_data_reg;
            best_diff_reg <= cand_diff;
        end
        if (ctrl_cmd.emit) begin
            if (best_valid_reg) begin
                res_dist_reg <= {1'b0, best_val_reg};
                res_diff_reg <= {1'b0, best_diff_reg};
            end else begin
                res_dist_reg <= NO_MATCH;
                res_diff_reg <= {1'b0, dist_reg} + RES_W'(1);
            end
        end
    end

    assign status.scan_done = (sec_reg == SEC_DONE) && !rd_valid_reg;
    assign status.out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = {{(OUT_DATA_W - 2*RES_W){1'b0}}, res_diff_reg, res_dist_reg};

endmodule

/* sv/sonar_echo_nearest_match_core.sv */
// Top level of the sonar echo nearest-match block: controller plus datapath.
`timescale 1ns / 1ps

// Usage
//   s_ channel: one command word per handshake. tuser selects the command
//   (clear, add, query) and the sector of an add; tdata carries the echo
//   distance for an add and the heading and visual distance for a query.
//   m_ channel: one result word per query; clear and add give none.
//   cfg channel: writes a sector heading bound; always ready, index above
//   five is dropped. Write only while no query is in flight.
// Query flow
//   Clear and add take effect at acceptance. A query scans the sectors in
//   order, reading the echoes held in matching sectors and skipping the
//   others, then emits the echo nearest the query distance. The echo
//   memory, with separate write and read ports, reads one echo a cycle.
// Reset
//   Counts and bounds clear; stored echoes are never read until rewritten.
// Stall
//   A held result stays in the output register; the next word is still
//   taken, and a following query waits at its end until the register frees.
module sonar_echo_nearest_match_core
    import senm_pkg::*;
#(
    parameter int ECHOES_PER_SECTOR = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [15:0]           cfg_data,
    // Command words
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [15:0] echo_distance, [31:16] robot_heading, [47:32] robot_distance
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // [1:0] cmd, [3:2] sector
    input  logic [IN_USER_W-1:0]  s_tuser,
    // Result words
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [16:0] sonar_distance, [33:17] distance_difference, [39:34] zero
    output logic [OUT_DATA_W-1:0] m_tdata
);

    senm_cmd_t    ctrl_cmd;
    senm_status_t status;

    senm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .item_cmd (s_tuser[1:0]),
        .status   (status),
        .ctrl_cmd (ctrl_cmd)
    );

    senm_datapath #(
        .ECHOES_PER_SECTOR (ECHOES_PER_SECTOR)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .ctrl_cmd  (ctrl_cmd),
        .status    (status)
    );

endmodule

/* verif/testbench.sv */
// Testbench for the sonar echo nearest-match core: directed and random command words.
`timescale 1ns / 1ps

module testbench;
    import senm_pkg::*;

    localparam int ECHO_SLOTS = 16;
    // Longest query plus margin, waited out before a bound write and at the end
    localparam int DRAIN_CYCLES = 3 * ECHO_SLOTS + 3 + 16;
    localparam int CFG_SLOTS = 1 << CFG_IDX_W;
    localparam int WORDS_PER_SETTING = 112;

    typedef struct packed {
        logic [RES_W-1:0] sonar;
        logic [RES_W-1:0] gap;
    } echo_match_t;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [SEC_W-1:0]  sec;
        logic [DIST_W-1:0] echo;
        logic [HEAD_W-1:0] heading;
        logic [DIST_W-1:0] rdist;
        logic              load;
        logic              typed;
        logic [RES_W-1:0]  sonar;
        logic [RES_W-1:0]  gap;
    } directed_word_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [15:0]           cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [IN_USER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    // Mirror of the block's state
    logic [DIST_W-1:0]   echo_bank [NUM_SECTORS][ECHO_SLOTS];
    int                  echo_fill [NUM_SECTORS];
    logic signed [15:0]  window_bound [NUM_CFG_REGS];
    logic [15:0]         cfg_plan [CFG_SLOTS];

    echo_match_t awaited_matches [$];

    int send_idle_pct = 0;
    int stall_pct = 0;
    int words_sent = 0;
    int matches_checked = 0;
    int settings_loaded = 0;
    int mismatches = 0;

    // Directed words: reset bounds first, then fixed windows from row six on
    directed_word_t directed_words [0:21] = '{
        '{CMD_QUERY, SEC_LEFT, 16'd0, 16'h0000, 16'd0, 1'b0, 1'b1, NO_MATCH, 17'd1},
        '{CMD_ADD, SEC_LEFT, 16'd0, 16'h0000, 16'd0, 1'b0, 1'b0, '0, '0},
        '{CMD_ADD, SEC_MIDDLE, 16'hFFFF, 16'h0000, 16'd0, 1'b0, 1'b0, '0, '0},
        '{CMD_QUERY, SEC_LEFT, 16'd0, 16'h0000, 16'hFFFF, 1'b0, 1'b1, NO_MATCH, 17'h10000},
        '{CMD_NONE, SEC_DONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, '0, '0},
        '{CMD_ADD, SEC_DONE, 16'd1234, 16'h0000, 16'd0, 1'b0, 1'b0, '0, '0},
        '{CMD_QUERY, SEC_LEFT, 16'd0, 16'h8000, 16'd0, 1'b1, 1'b0, '0, '0},
        '{CMD_QUERY, SEC_LEFT, 16'd0, 16'hFF9C, 16'd30000, 1'b0, 1'b0, '0, '0},
        '{CMD_ADD, SEC_LEFT, 16'd40000, 16'h0000, 16'd0, 1'b0, 1'b0, '0, '0},
        '{CMD_QUERY, SEC_LEFT, 16'd0, 16'hFF9C, 16'd20000, 1'b0, 1'b0, '0, '0},
        '{CMD_ADD, SEC_MIDDLE, 16'd100, 16'h0000, 16'd0, 1'b0, 1'b0, '0, '0},
        '{CMD_QUERY, SEC_LEFT, 16'd0, 16'hFFFF, 16'd300, 1'b0, 1'b0, '0, '0},
        '{CMD_QUERY, SEC_LEFT, 16'd0, 16'h0001, 16'd50, 1'b0, 1'b0, '0, '0},
        '{CMD_ADD, SEC_RIGHT, 16'd100, 16'h0000, 16'd0, 1'b0, 1'b0, '0, '0},
        '{CMD_QUERY, SEC_LEFT, 16'd0, 16'h0001, 16'd100, 1'b0, 1'b0, '0, '0},
        '{CMD_QUERY, SEC_LEFT, 16'd0, 16'h7FFF, 16'd0, 1'b0, 1'b0, '0, '0},
        '{CMD_QUERY, SEC_LEFT, 16'd0, 16'h0000, 16'hFFFF, 1'b0, 1'b0, '0, '0},
        '{CMD_CLEAR, SEC_LEFT, 16'd0, 16'h0000, 16'd0, 1'b0, 1'b0, '0, '0},
        '{CMD_QUERY, SEC_LEFT, 16'd0, 16'hFFFF, 16'd7, 1'b0, 1'b1, NO_MATCH, 17'd8},
        '{CMD_ADD, SEC_LEFT, 16'hFFFF, 16'h0000, 16'd0, 1'b0, 1'b0, '0, '0},
        '{CMD_QUERY, SEC_LEFT, 16'd0, 16'hFFFF, 16'd0, 1'b0, 1'b1, 17'h0FFFF, 17'h0FFFF},
        '{CMD_QUERY, SEC_LEFT, 16'd0, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 17'h0FFFF, 17'd0}
    };

    sonar_echo_nearest_match_core #(
        .ECHOES_PER_SECTOR(ECHO_SLOTS)
    ) i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic int abs_gap(input int a, input int b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Nearest echo over the sectors whose open window holds the heading
    function automatic echo_match_t nearest_echo(input logic [HEAD_W-1:0] heading,
                                                 input logic [DIST_W-1:0] rdist);
        echo_match_t r;
        int h, d, best, cand, lo, hi, g;
        h = $signed(heading);
        d = rdist;
        best = -1;
        for (int s = 0; s < NUM_SECTORS; s++) begin
            lo = window_bound[2 * s];
            hi = window_bound[2 * s + 1];
            if (lo < h && h < hi && echo_fill[s] > 0) begin
                cand = echo_bank[s][0];
                // first echo keeps a tie within the sector
                for (int i = 1; i < echo_fill[s]; i++)
                    if (abs_gap(d, echo_bank[s][i]) < abs_gap(d, cand))
                        cand = echo_bank[s][i];
                // a later sector wins only when strictly nearer
                if (best == -1 || abs_gap(best, d) > abs_gap(cand, d))
                    best = cand;
            end
        end
        g = abs_gap(d, best);
        r.sonar = best[RES_W-1:0];
        r.gap = g[RES_W-1:0];
        return r;
    endfunction

    // Heading near a window edge, at an extreme, or anywhere
    function automatic logic [HEAD_W-1:0] pick_heading();
        logic [HEAD_W-1:0] b;
        b = window_bound[$urandom_range(0, NUM_CFG_REGS - 1)];
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2, 3: return b;
            4: return b + 16'd1;
            5: return b - 16'd1;
            default: return 16'($urandom);
        endcase
    endfunction

    // Fill the bound plan; full_range opens every window to the full range
    function automatic void plan_windows(input bit full_range);
        logic signed [15:0] a, b;
        for (int s = 0; s < NUM_SECTORS; s++) begin
            a = 16'($urandom);
            b = 16'($urandom);
            if (full_range) begin
                a = 16'h8000;
                b = 16'h7FFF;
            end else begin
                case ($urandom_range(0, 9))
                    0: begin a = 16'h8000; b = 16'h7FFF; end
                    1: b = a;
                    2: begin a = 16'h7FFF; b = 16'h8000; end
                    3: ;
                    default: begin
                        if (a > b) begin
                            a = b;
                            b = 16'($urandom);
                        end
                    end
                endcase
                // keep most windows ordered
                if ($urandom_range(0, 9) > 3 && a > b) begin
                    a = a ^ b;
                    b = a ^ b;
                    a = a ^ b;
                end
            end
            cfg_plan[2 * s] = a;
            cfg_plan[2 * s + 1] = b;
        end
        for (int i = NUM_CFG_REGS; i < CFG_SLOTS; i++)
            cfg_plan[i] = 16'($urandom);
    endfunction

    // Write every bound slot, the unused indexes too
    task automatic load_bounds();
        for (int i = 0; i < CFG_SLOTS; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data <= cfg_plan[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            if (i < NUM_CFG_REGS)
                window_bound[i] = cfg_plan[i];
        end
        cfg_valid <= 1'b0;
        settings_loaded++;
    endtask

    // Hand one command word over, then update the mirror at its acceptance
    task automatic push_word(input logic [1:0] cmd, input logic [SEC_W-1:0] sec,
                             input logic [DIST_W-1:0] echo,
                             input logic [HEAD_W-1:0] heading,
                             input logic [DIST_W-1:0] rdist, input logic typed,
                             input logic [RES_W-1:0] t_sonar,
                             input logic [RES_W-1:0] t_gap);
        echo_match_t r;
        int s;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {rdist, heading, echo};
        s_tuser <= {sec, cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        s = sec;
        case (cmd)
            CMD_CLEAR: begin
                foreach (echo_fill[k]) echo_fill[k] = 0;
            end
            CMD_ADD: begin
                // drop adds to a full or unknown sector
                if (sec != SEC_DONE && echo_fill[s] < ECHO_SLOTS) begin
                    echo_bank[s][echo_fill[s]] = echo;
                    echo_fill[s]++;
                end
            end
            CMD_QUERY: begin
                r = nearest_echo(heading, rdist);
                if (typed) begin
                    r.sonar = t_sonar;
                    r.gap = t_gap;
                end
                awaited_matches.push_back(r);
            end
            default: ;
        endcase
        if (cmd != CMD_NONE && !(cmd == CMD_ADD && sec == SEC_DONE))
            words_sent++;
    endtask

    // Drop valid, wait for every awaited word, then let any query finish
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (awaited_matches.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Receiver back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Compare each result word with the oldest awaited match
    always @(posedge aclk) begin
        echo_match_t exp_match;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_matches.size() == 0) begin
                $error("result word with no query awaiting it: 0x%010h", m_tdata);
                mismatches++;
            end else begin
                exp_match = awaited_matches.pop_front();
                matches_checked++;
                if (m_tdata[RES_W-1:0] !== exp_match.sonar) begin
                    $error("sonar_distance: expected 0x%05h, got 0x%05h",
                           exp_match.sonar, m_tdata[RES_W-1:0]);
                    mismatches++;
                end
                if (m_tdata[2*RES_W-1:RES_W] !== exp_match.gap) begin
                    $error("distance_difference: expected 0x%05h, got 0x%05h",
                           exp_match.gap, m_tdata[2*RES_W-1:RES_W]);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        int send_mix [4];
        int stall_mix [4];
        int target, n_add, n_query;
        logic [DIST_W-1:0] anchor, echo, probe;
        logic [SEC_W-1:0] sec;

        send_mix = '{0, 53, 0, 29};
        stall_mix = '{0, 0, 53, 29};
        foreach (echo_fill[k]) echo_fill[k] = 0;
        foreach (window_bound[k]) window_bound[k] = '0;

        // hold reset low, then release it
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed words
        foreach (directed_words[k]) begin
            if (directed_words[k].load) begin
                settle();
                cfg_plan[REG_LEFT_START] = 16'h8000;
                cfg_plan[REG_LEFT_STOP] = 16'h0000;
                cfg_plan[REG_MIDDLE_START] = 16'hC000;
                cfg_plan[REG_MIDDLE_STOP] = 16'h4000;
                cfg_plan[REG_RIGHT_START] = 16'h0000;
                cfg_plan[REG_RIGHT_STOP] = 16'h7FFF;
                for (int i = NUM_CFG_REGS; i < CFG_SLOTS; i++)
                    cfg_plan[i] = 16'($urandom);
                load_bounds();
            end
            push_word(directed_words[k].cmd, directed_words[k].sec, directed_words[k].echo,
                      directed_words[k].heading, directed_words[k].rdist,
                      directed_words[k].typed, directed_words[k].sonar,
                      directed_words[k].gap);
        end

        // random rounds: usually a clear, a burst of adds, then queries, with some noise
        for (int p = 0; p < 4; p++) begin
            for (int half = 0; half < 2; half++) begin
                settle();
                send_idle_pct = send_mix[p];
                stall_pct = stall_mix[p];
                plan_windows(p == 0 && half == 0);
                load_bounds();
                target = words_sent + WORDS_PER_SETTING;
                while (words_sent < target) begin
                    anchor = 16'($urandom);
                    if ($urandom_range(0, 9) != 0)
                        push_word(CMD_CLEAR, SEC_W'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom), 1'b0, '0, '0);
                    n_add = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 40)
                                                        : $urandom_range(0, 12);
                    repeat (n_add) begin
                        sec = ($urandom_range(0, 19) == 0) ? SEC_DONE
                                                           : SEC_W'($urandom_range(0, 2));
                        case ($urandom_range(0, 7))
                            0: echo = '0;
                            1: echo = '1;
                            2, 3: echo = 16'($urandom);
                            default: echo = anchor + 16'($urandom_range(0, 40)) - 16'd20;
                        endcase
                        push_word(CMD_ADD, sec, echo, 16'($urandom), 16'($urandom),
                                  1'b0, '0, '0);
                    end
                    n_query = $urandom_range(1, 8);
                    repeat (n_query) begin
                        case ($urandom_range(0, 7))
                            0: probe = '0;
                            1: probe = '1;
                            2: probe = 16'($urandom);
                            default: probe = anchor + 16'($urandom_range(0, 20)) - 16'd10;
                        endcase
                        push_word(CMD_QUERY, SEC_W'($urandom), 16'($urandom), pick_heading(),
                                  probe, 1'b0, '0, '0);
                    end
                    // unknown command or fully random word now and then
                    if ($urandom_range(0, 9) == 0)
                        push_word(CMD_NONE, SEC_W'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom), 1'b0, '0, '0);
                    if ($urandom_range(0, 4) == 0)
                        push_word(2'($urandom), SEC_W'($urandom), 16'($urandom), pick_heading(),
                                  16'($urandom), 1'b0, '0, '0);
                end
            end
        end

        settle();
        $display("Sent %0d command words and checked %0d query results", words_sent,
                 matches_checked);
        $display("across %0d heading window settings and four flow-control mixes.",
                 settings_loaded);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Hard stop well past the slowest correct run
    initial begin
        #15_000_000;
        $display("Timed out with %0d results still awaited", awaited_matches.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule

/* filelist.f */
sv/senm_pkg.sv
sv/senm_ctrl.sv
sv/senm_datapath.sv
sv/sonar_echo_nearest_match_core.sv
verif/testbench.sv
